// ===== rtl/urlf_pkg.sv =====
// urlf_pkg: shared types and constants for the line-buffered UART receive FIFO.
// Holds the request/response beat structs, the command and state enums, and byte codes.
// No dependencies.
package urlf_pkg;

   // Default ring depth; the store holds at most DEPTH-1 bytes
   localparam int DEPTH_DEFAULT = 64;

   // Field widths fixed by the interface
   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 6;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_RECV  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EOL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOLINE = 2'd2;

   // Byte codes
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

   // Line counter saturates here
   localparam logic [COUNT_W-1:0] LINES_MAX = 6'd63;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = 1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  data_byte;
      logic [COUNT_W-1:0] line_length;
      logic [COUNT_W-1:0] lines_waiting;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_RECV,
      OP_READ,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] rx_byte;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DROP,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

endpackage

// ===== rtl/urlf_ram.sv =====
// urlf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module urlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/urlf_front.sv =====
// urlf_front: accepts request beats, turns the mode into a command and queues it.
// Depends on urlf_pkg. Unused mode codes are accepted and dropped here.
module urlf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  urlf_pkg::req_type req,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output urlf_pkg::cmd_type cmd
);

   urlf_pkg::cmd_type        entry_ff [urlf_pkg::QDEPTH];
   urlf_pkg::cmd_type        new_cmd;
   logic [urlf_pkg::QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [urlf_pkg::QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [urlf_pkg::QAW:0]   count_ff, count_in;
   logic                     known_mode;
   logic                     push;

   // classify the mode
   always_comb begin
      new_cmd.rx_byte = req.rx_byte;
      new_cmd.op      = urlf_pkg::OP_RECV;
      known_mode      = 1'b1;
      case (req.mode)
         urlf_pkg::MODE_RECV:  new_cmd.op = urlf_pkg::OP_RECV;
         urlf_pkg::MODE_READ:  new_cmd.op = urlf_pkg::OP_READ;
         urlf_pkg::MODE_FLUSH: new_cmd.op = urlf_pkg::OP_FLUSH;
         default:              known_mode = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == (urlf_pkg::QAW+1)'(urlf_pkg::QDEPTH));
   assign push      = req_valid && !req_stall && known_mode;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/urlf_back.sv =====
// urlf_back: executes queued commands on the byte ring and drives the response register.
// Depends on urlf_pkg and urlf_ram.
module urlf_back #(
   parameter int DEPTH = urlf_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  urlf_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output urlf_pkg::rsp_type rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [urlf_pkg::COUNT_W-1:0] LEN_CAP = urlf_pkg::COUNT_W'(DEPTH - 1);

   urlf_pkg::state_type          state_ff, state_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [AW-1:0]                rp_ff, rp_in;
   logic [urlf_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [urlf_pkg::COUNT_W-1:0] len_ff, len_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   urlf_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         ram_we;
   logic [urlf_pkg::BYTE_W-1:0]  rd_data;
   logic [AW-1:0]                wp_step, rp_step;
   logic                         out_free;
   logic                         rd_is_lf, rd_is_cr;
   logic                         emit;
   urlf_pkg::rsp_type            emit_beat;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // byte ring, read port always points at the oldest byte
   urlf_ram #(
      .WIDTH (urlf_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (cmd.rx_byte),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   assign wp_step  = ptr_next(wp_ff);
   assign rp_step  = ptr_next(rp_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_is_lf = (rd_data == urlf_pkg::CHAR_LF);
   assign rd_is_cr = (rd_data == urlf_pkg::CHAR_CR);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         urlf_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  urlf_pkg::OP_RECV: begin
                     if (wp_step == rp_ff) begin
                        state_in = urlf_pkg::ST_DROP;
                     end
                  end
                  urlf_pkg::OP_READ: begin
                     if (cnt_ff != '0) begin
                        state_in = urlf_pkg::ST_RD_ISSUE;
                     end
                  end
                  default: state_in = urlf_pkg::ST_IDLE;
               endcase
            end
         end
         urlf_pkg::ST_DROP:     state_in = urlf_pkg::ST_IDLE;
         urlf_pkg::ST_RD_ISSUE: state_in = urlf_pkg::ST_RD_DATA;
         urlf_pkg::ST_RD_DATA: begin
            // skipped bytes move on without waiting for the receiver
            if (rd_is_cr || (!rd_is_lf && len_ff >= LEN_CAP)) begin
               state_in = urlf_pkg::ST_RD_ISSUE;
            end else if (out_free) begin
               state_in = rd_is_lf ? urlf_pkg::ST_IDLE : urlf_pkg::ST_RD_ISSUE;
            end
         end
         default: state_in = urlf_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      emit         = 1'b0;
      emit_beat    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         urlf_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  urlf_pkg::OP_RECV: begin
                     // store byte; an overwrite is finished in ST_DROP
                     cmd_pop = 1'b1;
                     ram_we  = 1'b1;
                     wp_in   = wp_step;
                     if (cmd.rx_byte == urlf_pkg::CHAR_LF && cnt_ff < urlf_pkg::LINES_MAX) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  urlf_pkg::OP_READ: begin
                     if (cnt_ff == '0) begin
                        // no complete line: single beat
                        if (out_free) begin
                           cmd_pop        = 1'b1;
                           emit           = 1'b1;
                           emit_beat.kind = urlf_pkg::KIND_NOLINE;
                           emit_beat.last = 1'b1;
                        end
                     end else begin
                        cmd_pop = 1'b1;
                        len_in  = '0;
                     end
                  end
                  urlf_pkg::OP_FLUSH: begin
                     cmd_pop = 1'b1;
                     rp_in   = wp_ff;
                     cnt_in  = '0;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         urlf_pkg::ST_DROP: begin
            // oldest byte is dropped
            rp_in = rp_step;
            if (rd_is_lf && cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         urlf_pkg::ST_RD_ISSUE: begin
            // read of rp in flight
         end
         urlf_pkg::ST_RD_DATA: begin
            emit_beat.lines_waiting = cnt_ff - 1'b1;
            if (rd_is_cr) begin
               rp_in = rp_step;
            end else if (rd_is_lf) begin
               if (out_free) begin
                  rp_in                 = rp_step;
                  cnt_in                = cnt_ff - 1'b1;
                  emit                  = 1'b1;
                  emit_beat.kind        = urlf_pkg::KIND_EOL;
                  emit_beat.line_length = len_ff;
                  emit_beat.last        = 1'b1;
               end
            end else if (len_ff >= LEN_CAP) begin
               rp_in = rp_step;
            end else if (out_free) begin
               rp_in                 = rp_step;
               len_in                = len_ff + 1'b1;
               emit                  = 1'b1;
               emit_beat.kind        = urlf_pkg::KIND_DATA;
               emit_beat.data_byte   = rd_data;
               emit_beat.line_length = len_ff + 1'b1;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_beat;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urlf_pkg::ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/uart_rx_line_fifo.sv =====
// uart_rx_line_fifo: top level of the line-buffered UART receive FIFO.
// Depends on urlf_pkg, urlf_front and urlf_back (which holds urlf_ram).
// Usage:
//   req channel (req_valid/req_stall/req): one beat per command. mode 0 stores
//   rx_byte, mode 1 reads the oldest complete line, mode 2 flushes the store.
//   mode 3 is accepted and ignored.
//   rsp channel (rsp_valid/rsp_stall/rsp): line bytes with CR and LF removed,
//   then an end-of-line beat carrying the length; a read with no complete line
//   gives one no-line beat. last marks the final beat of a command.
// Command handling:
//   A two-entry command queue sits between the front and the back, so requests
//   are taken while the back is busy or the receiver stalls.
//   Receive stores the byte; a full store also drops the oldest byte in ST_DROP.
//   Flush and no-line read finish in ST_IDLE. A line read takes each stored byte
//   (including CR and LF) through ST_RD_ISSUE and ST_RD_DATA, as the byte RAM
//   has a registered read port. A line read's first beat is registered from
//   ST_RD_DATA (a leading CR repeats both states); a no-line beat, from ST_IDLE.
// Reset: clears pointers, line count, queue and response valid; RAM is not cleared.
// Stall: a stalled response beat holds; the back waits, and once the queue is
//   full req_stall rises.
module uart_rx_line_fifo #(
   parameter int DEPTH = urlf_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  urlf_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output urlf_pkg::rsp_type rsp
);

   logic              cmd_valid;
   logic              cmd_pop;
   urlf_pkg::cmd_type cmd;

   // accept and classify
   urlf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // execute on the ring
   urlf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// ===== rtl/urlf_checker.sv =====
// urlf_checker: port-level assertions for uart_rx_line_fifo, bound to the top level.
// Depends on urlf_pkg.
module urlf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input urlf_pkg::rsp_type rsp
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("response beat changed while stalled");

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // data beats carry a real line byte and never close the command
   a_data_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind == urlf_pkg::KIND_DATA |->
         !rsp.last && rsp.line_length != '0 &&
         rsp.data_byte != urlf_pkg::CHAR_LF && rsp.data_byte != urlf_pkg::CHAR_CR)
      else $error("bad line data beat");

   // end-of-line and no-line beats close the command with zero data
   a_close_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.kind == urlf_pkg::KIND_EOL || rsp.kind == urlf_pkg::KIND_NOLINE) |->
         rsp.last && rsp.data_byte == '0)
      else $error("bad closing beat");

   // no-line beat reports nothing waiting
   a_noline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind == urlf_pkg::KIND_NOLINE |->
         rsp.line_length == '0 && rsp.lines_waiting == '0)
      else $error("no-line beat with nonzero counts");

endmodule

bind uart_rx_line_fifo urlf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ===== tb/sv/tb_uart_rx_line_fifo.sv =====
// tb_uart_rx_line_fifo: self-checking bench for the line-buffered UART receive FIFO.
// Uses urlf_pkg types; a line tracker predicts every response beat and checks it in order.
// Needs only the RTL of uart_rx_line_fifo and its package.
module tb_uart_rx_line_fifo;
   import urlf_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;

   // Tracks ring contents and line count, holds the response beats still owed
   class line_fifo_tracker;
      logic [BYTE_W-1:0]  ring [RING_DEPTH];
      int unsigned        wr_ptr;
      int unsigned        rd_ptr;
      logic [COUNT_W-1:0] lines;
      rsp_type            beats_due [$];
      int                 errors;

      function new();
         wr_ptr = 0;
         rd_ptr = 0;
         lines  = '0;
         errors = 0;
      endfunction

      function int unsigned ptr_step(int unsigned p);
         return (p == RING_DEPTH - 1) ? 0 : p + 1;
      endfunction

      function void queue_beat(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data, int len,
                               logic [COUNT_W-1:0] waiting, logic last);
         rsp_type r;
         r.kind          = kind;
         r.data_byte     = data;
         r.line_length   = len[COUNT_W-1:0];
         r.lines_waiting = waiting;
         r.last          = last;
         beats_due.push_back(r);
      endfunction

      // Apply one accepted request beat and queue the beats it owes
      function void take_request(req_type item);
         logic [BYTE_W-1:0] line_bytes [$];
         logic [BYTE_W-1:0] c;
         int                steps;
         bit                done;
         case (item.mode)
            MODE_RECV: begin
               ring[wr_ptr] = item.rx_byte;
               wr_ptr = ptr_step(wr_ptr);
               if (item.rx_byte == CHAR_LF && lines < LINES_MAX) lines++;
               // full: oldest byte drops, and its line with it if it was a newline
               if (wr_ptr == rd_ptr) begin
                  if (ring[rd_ptr] == CHAR_LF && lines > 0) lines--;
                  rd_ptr = ptr_step(rd_ptr);
               end
            end
            MODE_READ: begin
               if (lines == 0) begin
                  queue_beat(KIND_NOLINE, '0, 0, '0, 1'b1);
               end else begin
                  steps = 0;
                  done  = 0;
                  while (!done && steps < RING_DEPTH) begin
                     c = ring[rd_ptr];
                     rd_ptr = ptr_step(rd_ptr);
                     steps++;
                     if (c == CHAR_LF) begin
                        lines--;
                        done = 1;
                     end else if (c != CHAR_CR && line_bytes.size() < RING_DEPTH - 1) begin
                        line_bytes.push_back(c);
                     end
                  end
                  foreach (line_bytes[k]) queue_beat(KIND_DATA, line_bytes[k], k + 1, lines, 1'b0);
                  queue_beat(KIND_EOL, '0, line_bytes.size(), lines, 1'b1);
               end
            end
            MODE_FLUSH: begin
               rd_ptr = wr_ptr;
               lines  = '0;
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted response beat with the oldest one owed
      function void check_response(rsp_type got);
         rsp_type want;
         if (beats_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected rsp beat: kind %0d data %h len %0d waiting %0d last %0d",
                        got.kind, got.data_byte, got.line_length, got.lines_waiting, got.last);
            return;
         end
         want = beats_due.pop_front();
         if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
             got.line_length !== want.line_length || got.lines_waiting !== want.lines_waiting ||
             got.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("rsp mismatch: want kind %0d data %h len %0d waiting %0d last %0d",
                        want.kind, want.data_byte, want.line_length, want.lines_waiting,
                        want.last);
               $display("              got  kind %0d data %h len %0d waiting %0d last %0d",
                        got.kind, got.data_byte, got.line_length, got.lines_waiting,
                        got.last);
            end
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req       = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          sent_items    = 0;
   int unsigned cycles        = 0;
   line_fifo_tracker tracker  = new();

   uart_rx_line_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp);
   end

   // Run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL uart_rx_line_fifo");
         $finish;
      end
   end

   // One request beat, with random idle cycles ahead of it
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] value);
      req_type item;
      item.mode    = mode;
      item.rx_byte = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_request(item);
      if (mode != MODE_IGNORED) sent_items++;
   endtask

   // Sender holds off until every owed beat has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.beats_due.size() != 0) @(posedge clock);
   endtask

   // Well-formed line: random bytes (no LF), optional CR, then LF
   task automatic send_line(input int len);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < len; i++) begin
         b = BYTE_W'($urandom_range(255));
         if (b == CHAR_LF) b = CHAR_CR;
         send_request(MODE_RECV, b);
      end
      if ($urandom_range(3) == 0) send_request(MODE_RECV, CHAR_CR);
      send_request(MODE_RECV, CHAR_LF);
   endtask

   // Overrun the ring so old bytes, newlines among them, get dropped
   task automatic flood_store(input bit all_lf);
      int n;
      n = $urandom_range(80, 64);
      repeat (n) begin
         if (all_lf || $urandom_range(3) == 0) send_request(MODE_RECV, CHAR_LF);
         else send_request(MODE_RECV, BYTE_W'($urandom_range(255)));
      end
   endtask

   task automatic run_random(input int target);
      int choice;
      sent_items = 0;
      while (sent_items < target) begin
         choice = $urandom_range(99);
         if (choice < 50) begin
            send_line(($urandom_range(9) == 0) ? $urandom_range(62) : $urandom_range(12));
            if ($urandom_range(9) < 6) send_request(MODE_READ, BYTE_W'($urandom_range(255)));
         end else if (choice < 70) begin
            send_request(MODE_READ, BYTE_W'($urandom_range(255)));
         end else if (choice < 82) begin
            send_request(MODE_RECV, BYTE_W'($urandom_range(255)));
         end else if (choice < 86) begin
            send_request(MODE_FLUSH, BYTE_W'($urandom_range(255)));
         end else if (choice < 89) begin
            send_request(MODE_IGNORED, BYTE_W'($urandom_range(255)));
         end else if (choice < 92) begin
            flood_store($urandom_range(1) != 0);
         end else if (choice < 97) begin
            repeat ($urandom_range(8, 2)) send_request(MODE_READ, BYTE_W'($urandom_range(255)));
         end else begin
            hold_until_drained();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty read, ignored mode, empty line, extremes and CR stripping
      send_request(MODE_READ, 8'h00);
      send_request(MODE_IGNORED, 8'hFF);
      send_request(MODE_RECV, CHAR_LF);
      send_request(MODE_READ, 8'hFF);
      send_request(MODE_RECV, 8'h00);
      send_request(MODE_RECV, 8'hFF);
      send_request(MODE_RECV, CHAR_CR);
      send_request(MODE_RECV, 8'h41);
      send_request(MODE_RECV, CHAR_CR);
      send_request(MODE_RECV, CHAR_LF);
      send_request(MODE_READ, 8'h00);
      // flush drops a partial line
      send_request(MODE_RECV, 8'h41);
      send_request(MODE_FLUSH, 8'hFF);
      send_request(MODE_READ, 8'h00);
      // two lines queued, then one read too many
      send_request(MODE_RECV, 8'h55);
      send_request(MODE_RECV, 8'hAA);
      send_request(MODE_RECV, CHAR_LF);
      send_request(MODE_RECV, CHAR_CR);
      send_request(MODE_RECV, CHAR_LF);
      send_request(MODE_READ, 8'h00);
      send_request(MODE_READ, 8'h00);
      send_request(MODE_READ, 8'h00);
      hold_until_drained();

      // Random phases with different idle mixes
      send_idle_pct = 21;
      stall_pct     = 52;
      run_random(134);
      hold_until_drained();
      send_idle_pct = 52;
      stall_pct     = 21;
      run_random(133);
      hold_until_drained();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(133);

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.beats_due.size() == 0) begin
         $display("PASS uart_rx_line_fifo");
      end else begin
         $display("FAIL uart_rx_line_fifo");
      end
      $finish;
   end

endmodule
